[rtl/pwm_hex_command_parser_defines.svh]
// ----------------------------------------------------------------------------
// pwm_hex_command_parser_defines: assertion macros
// Shared assertion templates, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PWM_HEX_COMMAND_PARSER_DEFINES_SVH
`define PWM_HEX_COMMAND_PARSER_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define PHCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define PHCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/phcp_pkg.sv]
// ----------------------------------------------------------------------------
// phcp_pkg: shared types and constants
// Parser states, character codes and the decoded character record.
// ----------------------------------------------------------------------------
package phcp_pkg;

    localparam int NUM_CHANNELS = 6;

    localparam logic [7:0] CHAR_C  = 8'h43;
    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_F  = 8'h46;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_1  = 8'h31;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CHAN_LAST = 8'(CHAR_0 + NUM_CHANNELS);

    localparam logic [2:0] ADJ_DIGITS = 3'd4;

    localparam logic KIND_CHAN = 1'b0;
    localparam logic KIND_ADJ  = 1'b1;

    typedef enum logic [3:0] {
        ST_CMD     = 4'd0,
        ST_CV_CHAN = 4'd1,
        ST_CV_HI   = 4'd2,
        ST_CV_LO   = 4'd3,
        ST_CV_END  = 4'd4,
        ST_AV_CHAN = 4'd5,
        ST_AV_DIG  = 4'd6,
        ST_AV_END  = 4'd7,
        ST_EOL     = 4'd8
    } t_parse_state;

    typedef struct packed {
        logic       is_c;
        logic       is_a;
        logic       is_eol;
        logic       hex_ok;
        logic [3:0] nibble;
        logic       chan_ok;
        logic [2:0] chan_idx;
    } t_char_info;

endpackage

[rtl/pwm_hex_command_parser.sv]
// ----------------------------------------------------------------------------
// pwm_hex_command_parser: line command parser for pwm channel writes
// Parses ASCII "C n hh" and "A n xxxx" lines into channel write events.
// ----------------------------------------------------------------------------
// Usage:
//   slave side takes one ASCII byte per transfer in i_s_tdata[7:0].
//   "C", channel digit, two uppercase hex digits, then CR or LF gives a
//   channel value write; "A", channel digit, four hex characters, then CR or
//   LF gives an adjust value write. Anything unexpected skips to line end.
//   master side carries one write event per transfer: tuser holds the kind,
//   tdata the channel and the value.
// Timing and throughput:
//   one byte per cycle while the result register is empty or draining. The
//   event appears on the master side in the cycle after the transfer of the
//   closing line end byte; the parser state and the result are registered.
// Reset:
//   synchronous, active low; the parser waits for a command and no event is
//   pending.
// Stall:
//   a pending event is held in the result register; bytes keep being taken
//   while it drains, and input stalls only when it is full and not taken.
// ----------------------------------------------------------------------------
`include "pwm_hex_command_parser_defines.svh"

module pwm_hex_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_char
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [2:0] channel, [18:3] value, rest zero
    output logic [0:0]  o_m_tuser    // [0] write_kind
);
    import phcp_pkg::*;

    t_char_info   ch;
    t_parse_state r_state, n_state;
    logic [2:0]   r_chan, n_chan;
    logic [15:0]  r_acc, n_acc;
    logic [2:0]   r_count, n_count;
    logic         r_bad, n_bad;
    logic         emit;
    logic         s_xfer;
    logic         out_is_chan;

    logic         r_out_valid;
    logic         r_out_kind;
    logic [2:0]   r_out_chan;
    logic [15:0]  r_out_value;
    logic         n_out_kind;
    logic [15:0]  n_out_value;

    phcp_char_decode u_decode (
        .i_char (i_s_tdata),
        .o_info (ch)
    );

    // no byte is taken while in reset
    assign o_s_tready = i_rst_n && (!r_out_valid || i_m_tready);
    assign s_xfer     = i_s_tvalid && o_s_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CMD: begin
                if (ch.is_c) begin
                    n_state = ST_CV_CHAN;
                end else if (ch.is_a) begin
                    n_state = ST_AV_CHAN;
                end else if (ch.is_eol) begin
                    n_state = ST_CMD;
                end else begin
                    n_state = ST_EOL;
                end
            end
            ST_CV_CHAN: begin
                n_state = ch.chan_ok ? ST_CV_HI : ST_EOL;
            end
            ST_AV_CHAN: begin
                n_state = ch.chan_ok ? ST_AV_DIG : ST_EOL;
            end
            ST_CV_HI: begin
                n_state = ch.hex_ok ? ST_CV_LO : ST_EOL;
            end
            ST_CV_LO: begin
                n_state = ch.hex_ok ? ST_CV_END : ST_EOL;
            end
            ST_AV_DIG: begin
                // judged only once all four characters are in
                if (n_count >= ADJ_DIGITS) begin
                    n_state = n_bad ? ST_EOL : ST_AV_END;
                end
            end
            ST_CV_END, ST_AV_END: begin
                n_state = ch.is_eol ? ST_CMD : ST_EOL;
            end
            default: begin
                n_state = ch.is_eol ? ST_CMD : ST_EOL;
            end
        endcase
    end

    // datapath and event
    always_comb begin
        n_chan      = r_chan;
        n_acc       = r_acc;
        n_count     = r_count;
        n_bad       = r_bad;
        emit        = 1'b0;
        n_out_kind  = KIND_CHAN;
        n_out_value = {8'd0, r_acc[7:0]};
        case (r_state)
            ST_CV_CHAN: begin
                if (ch.chan_ok) begin
                    n_chan = ch.chan_idx;
                end
            end
            ST_AV_CHAN: begin
                if (ch.chan_ok) begin
                    n_chan  = ch.chan_idx;
                    n_acc   = 16'd0;
                    n_count = 3'd0;
                    n_bad   = 1'b0;
                end
            end
            ST_CV_HI: begin
                if (ch.hex_ok) begin
                    n_acc = {12'd0, ch.nibble};
                end
            end
            ST_CV_LO: begin
                if (ch.hex_ok) begin
                    n_acc = {8'd0, r_acc[3:0], ch.nibble};
                end
            end
            ST_AV_DIG: begin
                n_acc   = {r_acc[11:0], ch.nibble};
                n_bad   = r_bad || !ch.hex_ok;
                n_count = r_count + 3'd1;
            end
            ST_CV_END: begin
                emit = ch.is_eol;
            end
            ST_AV_END: begin
                emit        = ch.is_eol;
                n_out_kind  = KIND_ADJ;
                n_out_value = r_acc;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CMD;
            r_chan  <= 3'd0;
            r_acc   <= 16'd0;
            r_count <= 3'd0;
            r_bad   <= 1'b0;
        end else if (s_xfer) begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_acc   <= n_acc;
            r_count <= n_count;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_xfer && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer && emit) begin
            r_out_kind  <= n_out_kind;
            r_out_chan  <= r_chan;
            r_out_value <= n_out_value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {5'd0, r_out_value, r_out_chan};

    assign out_is_chan = o_m_tvalid && (o_m_tuser[0] == KIND_CHAN);

    `PHCP_ASSERT_NEXT(a_eol_emits, s_xfer && emit, o_m_tvalid, "no event after closing line end")
    `PHCP_ASSERT_NOW(a_count_range, r_state == ST_AV_DIG, r_count < ADJ_DIGITS, "bad adjust count")
    `PHCP_ASSERT_NOW(a_chan_upper_zero, out_is_chan, o_m_tdata[18:11] == 8'd0, "upper value bits set")

endmodule

[rtl/phcp_char_decode.sv]
// ----------------------------------------------------------------------------
// phcp_char_decode: character classifier
// Classifies one received byte: command letters, line end, hex digit value
// and channel digit index.
// ----------------------------------------------------------------------------
module phcp_char_decode (
    input  logic [7:0]          i_char,
    output phcp_pkg::t_char_info o_info
);
    import phcp_pkg::*;

    logic is_dec;
    logic is_hex_alpha;

    always_comb begin
        is_dec       = (i_char >= CHAR_0) && (i_char <= CHAR_9);
        is_hex_alpha = (i_char >= CHAR_A) && (i_char <= CHAR_F);

        o_info.is_c   = (i_char == CHAR_C);
        o_info.is_a   = (i_char == CHAR_A);
        o_info.is_eol = (i_char == CHAR_CR) || (i_char == CHAR_LF);
        o_info.hex_ok = is_dec || is_hex_alpha;

        // only uppercase letters count, lowercase falls through as invalid
        if (is_hex_alpha) begin
            o_info.nibble = 4'(i_char - CHAR_A + 8'd10);
        end else begin
            o_info.nibble = 4'(i_char - CHAR_0);
        end

        o_info.chan_ok  = (i_char >= CHAR_1) && (i_char <= CHAR_CHAN_LAST);
        // index kept in three bits, so the ninth channel wraps to zero
        o_info.chan_idx = 3'(i_char - CHAR_1);
    end

endmodule

[tb/tb_pwm_hex_command_parser.sv]
// ----------------------------------------------------------------------------
// tb_pwm_hex_command_parser: stream testbench for the line command parser
// Feeds ASCII bytes (directed lines, then random well-formed commands mixed
// with corrupted lines and noise), predicts each channel or adjust write,
// and checks every write event that leaves the block against the prediction.
// ----------------------------------------------------------------------------
module tb_pwm_hex_command_parser;
    import phcp_pkg::*;

    localparam int          NUM_BYTES    = 1550;
    localparam int          CALM_BYTES   = 1350;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [7:0]  CHAR_LOW_A   = 8'h61;

    typedef struct packed {
        logic        kind;
        logic [2:0]  chan;
        logic [15:0] wr_value;
    } t_chan_write;

    // tracks the parser and holds the writes it should emit, oldest first
    class write_scoreboard;
        t_parse_state  pstate;
        logic [2:0]    chan;
        logic [15:0]   acc;
        logic [2:0]    ndig;
        logic          bad;
        t_chan_write   expected_writes[$];
        int            errors;
        int            n_bytes;
        int            n_chan_writes;
        int            n_adj_writes;

        function new();
            pstate = ST_CMD;
            chan   = '0;
            acc    = '0;
            ndig   = '0;
            bad    = 1'b0;
            errors = 0;
            n_bytes = 0;
            n_chan_writes = 0;
            n_adj_writes = 0;
        endfunction

        // 0..15 for an uppercase hex digit, 16 for anything else
        function logic [4:0] hex_value(logic [7:0] c);
            if (c >= CHAR_0 && c <= CHAR_9) return {1'b0, 4'(c - CHAR_0)};
            if (c >= CHAR_A && c <= CHAR_F) return {1'b0, 4'(c - CHAR_A + 8'd10)};
            return 5'h10;
        endfunction

        function void note_byte(logic [7:0] c);
            logic [4:0]   nib;
            logic         eol;
            logic [2:0]   cnt;
            logic         bad_now;
            t_chan_write  wr;
            nib = hex_value(c);
            eol = (c == CHAR_CR) || (c == CHAR_LF);
            n_bytes++;
            case (pstate)
                ST_CMD: begin
                    if (c == CHAR_C)      pstate = ST_CV_CHAN;
                    else if (c == CHAR_A) pstate = ST_AV_CHAN;
                    else if (eol)         pstate = ST_CMD;
                    else                  pstate = ST_EOL;
                end
                ST_CV_CHAN, ST_AV_CHAN: begin
                    if (c >= CHAR_1 && c <= CHAR_CHAN_LAST) begin
                        chan = 3'(c - CHAR_1);
                        if (pstate == ST_CV_CHAN) begin
                            pstate = ST_CV_HI;
                        end else begin
                            pstate = ST_AV_DIG;
                            ndig = '0;
                            bad  = 1'b0;
                            acc  = '0;
                        end
                    end else begin
                        pstate = ST_EOL;
                    end
                end
                ST_CV_HI: begin
                    if (!nib[4]) begin
                        acc = {12'h000, nib[3:0]};
                        pstate = ST_CV_LO;
                    end else begin
                        pstate = ST_EOL;
                    end
                end
                ST_CV_LO: begin
                    if (!nib[4]) begin
                        acc = {8'h00, acc[3:0], nib[3:0]};
                        pstate = ST_CV_END;
                    end else begin
                        pstate = ST_EOL;
                    end
                end
                ST_AV_DIG: begin
                    // invalid characters shift in as zero and are judged after the fourth
                    acc = {acc[11:0], nib[3:0]};
                    bad_now = bad | nib[4];
                    bad = bad_now;
                    cnt = ndig + 3'd1;
                    ndig = cnt;
                    if (cnt >= ADJ_DIGITS) pstate = bad_now ? ST_EOL : ST_AV_END;
                end
                ST_CV_END, ST_AV_END: begin
                    if (eol) begin
                        wr.kind     = (pstate == ST_AV_END) ? KIND_ADJ : KIND_CHAN;
                        wr.chan     = chan;
                        wr.wr_value = (pstate == ST_AV_END) ? acc : {8'h00, acc[7:0]};
                        expected_writes.push_back(wr);
                        pstate = ST_CMD;
                    end else begin
                        pstate = ST_EOL;
                    end
                end
                default: begin
                    pstate = eol ? ST_CMD : ST_EOL;
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_write(logic kind, logic [2:0] ch, logic [15:0] val);
            t_chan_write exp_wr;
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write kind=%0d chan=%0d value=%h",
                                          kind, ch, val));
                return;
            end
            exp_wr = expected_writes.pop_front();
            if (kind == KIND_ADJ) n_adj_writes++;
            else n_chan_writes++;
            if (kind !== exp_wr.kind)
                report_mismatch($sformatf("write_kind %0d, expected %0d", kind, exp_wr.kind));
            if (ch !== exp_wr.chan)
                report_mismatch($sformatf("channel %0d, expected %0d", ch, exp_wr.chan));
            if (val !== exp_wr.wr_value)
                report_mismatch($sformatf("value %h, expected %h", val, exp_wr.wr_value));
        endtask

        function int pending_count();
            return expected_writes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;    // [7:0] in_char
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;             // [2:0] channel, [18:3] value, rest zero
    logic [0:0]  o_m_tuser;             // [0] write_kind

    write_scoreboard sb = new();
    bit              idle_on  = 1'b1;
    bit              hold_req = 1'b0;
    int              cycles   = 0;

    pwm_hex_command_parser u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // all signals only move at the rising edge, so the falling edge sees
    // exactly what the next rising edge will take
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_byte(i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                sb.check_write(o_m_tuser[0], o_m_tdata[2:0], o_m_tdata[18:3]);
        end
    end

    // receiver: short random stalls, plus one long hold-off on request
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task send_byte(logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function logic [7:0] hex_char(int n);
        return (n < 10) ? 8'(CHAR_0 + n) : 8'(CHAR_A + n - 10);
    endfunction

    function logic [7:0] line_end();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    initial begin
        logic [7:0] line[$];
        int         n_sent;
        int         pick;
        int         pos;
        bit         is_adj;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines: value extremes, both line ends, bare line end,
        // line end among adjust characters, lowercase hex, channel out of range
        send_text("C100");
        send_byte(CHAR_CR);
        send_text("A6FFFF");
        send_byte(CHAR_LF);
        send_byte(CHAR_LF);
        send_text("A3");
        send_byte(CHAR_CR);
        send_text("12");
        send_byte(CHAR_LF);
        send_byte(CHAR_LF);
        send_text("C1a");
        send_byte(CHAR_LF);
        send_text("C7");
        send_byte(CHAR_CR);
        n_sent = 27;

        hold_req = 1'b1;
        while (n_sent < NUM_BYTES) begin
            line = {};
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                is_adj = (pick >= 4);
                line.push_back(is_adj ? CHAR_A : CHAR_C);
                line.push_back(8'(CHAR_1 + $urandom_range(0, NUM_CHANNELS - 1)));
                repeat (is_adj ? 4 : 2) line.push_back(hex_char($urandom_range(0, 15)));
                line.push_back(line_end());
                // some lines get one byte spoiled
                if ($urandom_range(0, 4) == 0) begin
                    pos = $urandom_range(0, line.size() - 1);
                    case ($urandom_range(0, 2))
                        0:       line[pos] = 8'($urandom_range(0, 255));
                        1:       line[pos] = 8'(CHAR_LOW_A + $urandom_range(0, 5));
                        default: line[pos] = line_end();
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 5)) line.push_back(8'($urandom_range(0, 255)));
                line.push_back(line_end());
            end
            foreach (line[i]) begin
                send_byte(line[i]);
                n_sent++;
            end
            if (n_sent > CALM_BYTES) idle_on = 1'b0;
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes, including noise and corrupted lines", sb.n_bytes);
        $display("checked %0d channel value writes and %0d adjust writes, %0d mismatches",
                 sb.n_chan_writes, sb.n_adj_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
